### hdl/kbpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbpt_pkg
// Shared field widths, limits and the command record that passes from the
// front end to the back end of the spanning forest block.
// ----------------------------------------------------------------------------
package kbpt_pkg;

    localparam int NODE_W  = 6;
    localparam int COST_W  = 30;
    localparam int TOTAL_W = 36;
    localparam int RANK_W  = 3;

    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic              query;
        logic              nodes_ok;
        logic              same_node;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [COST_W-1:0] cost;
    } cmd_t;

endpackage
`default_nettype wire

### hdl/kbpt_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbpt channels
// Valid/ready channels for incoming edge and query beats and for result beats.
// ----------------------------------------------------------------------------
interface kbpt_item_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [kbpt_pkg::NODE_W-1:0] node_a;
    logic [kbpt_pkg::NODE_W-1:0] node_b;
    logic [kbpt_pkg::COST_W-1:0] edge_cost;

    modport source (output valid, output operation, output node_a, output node_b,
                    output edge_cost, input ready);
    modport sink   (input valid, input operation, input node_a, input node_b,
                    input edge_cost, output ready);
endinterface

interface kbpt_result_if;
    logic                         valid;
    logic                         ready;
    logic                         merged;
    logic [kbpt_pkg::TOTAL_W-1:0] tree_weight;
    logic [kbpt_pkg::TOTAL_W-1:0] query_answer;

    modport source (output valid, output merged, output tree_weight,
                    output query_answer, input ready);
    modport sink   (input valid, input merged, input tree_weight,
                    input query_answer, output ready);
endinterface
`default_nettype wire

### hdl/kbpt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbpt_front
// Accepts beats and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
module kbpt_front #(
    parameter int NODE_COUNT = 64
) (
    kbpt_item_if.sink     item,
    input  logic          queue_full,
    input  logic          init_done,
    output logic          push,
    output kbpt_pkg::cmd_t push_cmd
);

    logic a_ok;
    logic b_ok;

    assign a_ok = (32'(item.node_a) < 32'(NODE_COUNT));
    assign b_ok = (32'(item.node_b) < 32'(NODE_COUNT));

    assign item.ready = init_done && !queue_full;
    assign push       = item.valid && item.ready;

    always_comb
    begin
        push_cmd.query     = (item.operation == kbpt_pkg::OP_QUERY);
        push_cmd.nodes_ok  = a_ok && b_ok;
        push_cmd.same_node = (item.node_a == item.node_b);
        push_cmd.node_a    = item.node_a;
        push_cmd.node_b    = item.node_b;
        push_cmd.cost      = item.edge_cost;
    end

endmodule
`default_nettype wire

### hdl/kbpt_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbpt_cmd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module kbpt_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kbpt_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output kbpt_pkg::cmd_t pop_cmd
);

    kbpt_pkg::cmd_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

### hdl/kbpt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbpt_back
// Sequencer that finds roots, records cross pair costs, merges components by
// rank and answers pair queries, with the forest and pair table in memories.
// ----------------------------------------------------------------------------
module kbpt_back #(
    parameter int NODE_COUNT = 64,
    parameter int COST_WIDTH = 30
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  kbpt_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           init_done,
    kbpt_result_if.source  result
);

    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PW = $clog2(NODE_COUNT * NODE_COUNT);
    localparam int TW = kbpt_pkg::TOTAL_W;
    localparam int RW = kbpt_pkg::RANK_W;

    typedef enum logic [15:0] {
        S_INIT   = 16'b0000_0000_0000_0001,
        S_IDLE   = 16'b0000_0000_0000_0010,
        S_FA_RD  = 16'b0000_0000_0000_0100,
        S_FA_CHK = 16'b0000_0000_0000_1000,
        S_FB_RD  = 16'b0000_0000_0001_0000,
        S_FB_CHK = 16'b0000_0000_0010_0000,
        S_PR_W1  = 16'b0000_0000_0100_0000,
        S_PR_W2  = 16'b0000_0000_1000_0000,
        S_NA_RD  = 16'b0000_0001_0000_0000,
        S_NA_CHK = 16'b0000_0010_0000_0000,
        S_MG_RD1 = 16'b0000_0100_0000_0000,
        S_MG_RD2 = 16'b0000_1000_0000_0000,
        S_MG_WR  = 16'b0001_0000_0000_0000,
        S_Q_RD   = 16'b0010_0000_0000_0000,
        S_Q_CHK  = 16'b0100_0000_0000_0000,
        S_DONE   = 16'b1000_0000_0000_0000
    } state_t;

    function automatic logic [PW-1:0] pair_addr(input logic [NW-1:0] x,
                                                input logic [NW-1:0] y);
        pair_addr = PW'(32'(x) * 32'(NODE_COUNT) + 32'(y));
    endfunction

    state_t state_reg;
    state_t state_next;

    kbpt_pkg::cmd_t  cmd_reg;
    kbpt_pkg::cmd_t  cmd_next;
    logic [COST_WIDTH-1:0] cost_reg;
    logic [COST_WIDTH-1:0] cost_next;
    logic [NW-1:0] cur_reg;
    logic [NW-1:0] cur_next;
    logic [NW-1:0] ru_reg;
    logic [NW-1:0] ru_next;
    logic [NW-1:0] rv_reg;
    logic [NW-1:0] rv_next;
    logic [NW-1:0] pa_reg;
    logic [NW-1:0] pa_next;
    logic [NW-1:0] pb_reg;
    logic [NW-1:0] pb_next;
    logic [NW-1:0] init_cnt_reg;
    logic [NW-1:0] init_cnt_next;
    logic [RW-1:0] rank_u_reg;
    logic [RW-1:0] rank_u_next;
    logic [NW-1:0] tail_u_reg;
    logic [NW-1:0] tail_u_next;
    logic [TW-1:0] total_reg;
    logic [TW-1:0] total_next;
    logic          pend_merged_reg;
    logic          pend_merged_next;
    logic [TW-1:0] pend_answer_reg;
    logic [TW-1:0] pend_answer_next;
    logic          res_valid_reg;
    logic          res_valid_next;
    logic          res_merged_reg;
    logic          res_merged_next;
    logic [TW-1:0] res_weight_reg;
    logic [TW-1:0] res_weight_next;
    logic [TW-1:0] res_answer_reg;
    logic [TW-1:0] res_answer_next;

    logic [NW-1:0]         par_mem  [NODE_COUNT];
    logic [RW-1:0]         rank_mem [NODE_COUNT];
    logic [NW-1:0]         next_mem [NODE_COUNT];
    logic [NW-1:0]         tail_mem [NODE_COUNT];
    logic [COST_WIDTH-1:0] pair_mem [NODE_COUNT * NODE_COUNT];

    logic [NW-1:0]         par_rd_reg;
    logic [RW-1:0]         rank_rd_reg;
    logic [NW-1:0]         next_rd_reg;
    logic [NW-1:0]         tail_rd_reg;
    logic [COST_WIDTH-1:0] pair_rd_reg;

    logic          par_we;
    logic [NW-1:0] par_wa;
    logic [NW-1:0] par_wd;
    logic [NW-1:0] par_ra;
    logic          rank_we;
    logic [NW-1:0] rank_wa;
    logic [RW-1:0] rank_wd;
    logic [NW-1:0] rank_ra;
    logic          next_we;
    logic [NW-1:0] next_wa;
    logic [NW-1:0] next_wd;
    logic [NW-1:0] next_ra;
    logic          tail_we;
    logic [NW-1:0] tail_wa;
    logic [NW-1:0] tail_wd;
    logic [NW-1:0] tail_ra;
    logic                  pair_we;
    logic [PW-1:0]         pair_wa;
    logic [COST_WIDTH-1:0] pair_wd;
    logic [PW-1:0]         pair_ra;

    logic          swap;
    logic [NW-1:0] lo_root;
    logic [NW-1:0] hi_root;
    logic [RW-1:0] lo_rank;
    logic [RW-1:0] hi_rank;
    logic [NW-1:0] lo_tail;
    logic [NW-1:0] hi_tail;
    logic [TW:0]   sum_wide;
    logic [TW-1:0] pair_cost;

    assign init_done = (state_reg != S_INIT);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    assign result.valid        = res_valid_reg;
    assign result.merged       = res_merged_reg;
    assign result.tree_weight  = res_weight_reg;
    assign result.query_answer = res_answer_reg;

    assign swap     = (rank_u_reg > rank_rd_reg);
    assign lo_root  = swap ? rv_reg : ru_reg;
    assign hi_root  = swap ? ru_reg : rv_reg;
    assign lo_rank  = swap ? rank_rd_reg : rank_u_reg;
    assign hi_rank  = swap ? rank_u_reg : rank_rd_reg;
    assign lo_tail  = swap ? tail_rd_reg : tail_u_reg;
    assign hi_tail  = swap ? tail_u_reg : tail_rd_reg;
    assign sum_wide = {1'b0, total_reg} + (TW + 1)'(cost_reg);
    assign pair_cost = TW'(pair_rd_reg);

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        cost_next        = cost_reg;
        cur_next         = cur_reg;
        ru_next          = ru_reg;
        rv_next          = rv_reg;
        pa_next          = pa_reg;
        pb_next          = pb_reg;
        init_cnt_next    = init_cnt_reg;
        rank_u_next      = rank_u_reg;
        tail_u_next      = tail_u_reg;
        total_next       = total_reg;
        pend_merged_next = pend_merged_reg;
        pend_answer_next = pend_answer_reg;
        res_valid_next   = res_valid_reg && !result.ready;
        res_merged_next  = res_merged_reg;
        res_weight_next  = res_weight_reg;
        res_answer_next  = res_answer_reg;

        par_we  = 1'b0;
        par_wa  = init_cnt_reg;
        par_wd  = init_cnt_reg;
        par_ra  = cur_reg;
        rank_we = 1'b0;
        rank_wa = init_cnt_reg;
        rank_wd = '0;
        rank_ra = ru_reg;
        next_we = 1'b0;
        next_wa = init_cnt_reg;
        next_wd = init_cnt_reg;
        next_ra = pb_reg;
        tail_we = 1'b0;
        tail_wa = init_cnt_reg;
        tail_wd = init_cnt_reg;
        tail_ra = ru_reg;
        pair_we = 1'b0;
        pair_wa = pair_addr(pa_reg, pb_reg);
        pair_wd = cost_reg;
        pair_ra = pair_addr(NW'(cmd_reg.node_a), NW'(cmd_reg.node_b));

        case (state_reg)
            S_INIT:
            begin
                par_we  = 1'b1;
                rank_we = 1'b1;
                next_we = 1'b1;
                tail_we = 1'b1;
                if (init_cnt_reg == NW'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + NW'(1);
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next         = q_cmd;
                    cost_next        = COST_WIDTH'(q_cmd.cost);
                    cur_next         = NW'(q_cmd.node_a);
                    pend_merged_next = 1'b0;
                    pend_answer_next = '0;
                    if (!q_cmd.query && !q_cmd.nodes_ok)
                    begin
                        state_next = S_DONE;
                    end
                    else if (q_cmd.query && (!q_cmd.nodes_ok || q_cmd.same_node))
                    begin
                        pend_answer_next = total_reg;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FA_RD;
                    end
                end
            end
            S_FA_RD:
            begin
                state_next = S_FA_CHK;
            end
            S_FA_CHK:
            begin
                if (par_rd_reg == cur_reg)
                begin
                    ru_next    = cur_reg;
                    cur_next   = NW'(cmd_reg.node_b);
                    state_next = S_FB_RD;
                end
                else
                begin
                    cur_next   = par_rd_reg;
                    state_next = S_FA_RD;
                end
            end
            S_FB_RD:
            begin
                state_next = S_FB_CHK;
            end
            S_FB_CHK:
            begin
                if (par_rd_reg == cur_reg)
                begin
                    rv_next = cur_reg;
                    if (cmd_reg.query)
                    begin
                        if (ru_reg == cur_reg)
                        begin
                            state_next = S_Q_RD;
                        end
                        else
                        begin
                            pend_answer_next = total_reg;
                            state_next       = S_DONE;
                        end
                    end
                    else if (ru_reg == cur_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pa_next    = ru_reg;
                        pb_next    = cur_reg;
                        state_next = S_PR_W1;
                    end
                end
                else
                begin
                    cur_next   = par_rd_reg;
                    state_next = S_FB_RD;
                end
            end
            S_PR_W1:
            begin
                pair_we    = 1'b1;
                pair_wa    = pair_addr(pa_reg, pb_reg);
                next_ra    = pb_reg;
                state_next = S_PR_W2;
            end
            S_PR_W2:
            begin
                pair_we = 1'b1;
                pair_wa = pair_addr(pb_reg, pa_reg);
                if (next_rd_reg == pb_reg)
                begin
                    state_next = S_NA_RD;
                end
                else
                begin
                    pb_next    = next_rd_reg;
                    state_next = S_PR_W1;
                end
            end
            S_NA_RD:
            begin
                next_ra    = pa_reg;
                state_next = S_NA_CHK;
            end
            S_NA_CHK:
            begin
                if (next_rd_reg == pa_reg)
                begin
                    state_next = S_MG_RD1;
                end
                else
                begin
                    pa_next    = next_rd_reg;
                    pb_next    = rv_reg;
                    state_next = S_PR_W1;
                end
            end
            S_MG_RD1:
            begin
                rank_ra    = ru_reg;
                tail_ra    = ru_reg;
                state_next = S_MG_RD2;
            end
            S_MG_RD2:
            begin
                rank_ra     = rv_reg;
                tail_ra     = rv_reg;
                rank_u_next = rank_rd_reg;
                tail_u_next = tail_rd_reg;
                state_next  = S_MG_WR;
            end
            S_MG_WR:
            begin
                par_we  = 1'b1;
                par_wa  = lo_root;
                par_wd  = hi_root;
                next_we = 1'b1;
                next_wa = hi_tail;
                next_wd = lo_root;
                tail_we = 1'b1;
                tail_wa = hi_root;
                tail_wd = lo_tail;
                rank_wa = hi_root;
                rank_wd = hi_rank + RW'(1);
                rank_we = (lo_rank == hi_rank) && (hi_rank < kbpt_pkg::RANK_MAX);
                total_next       = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
                pend_merged_next = 1'b1;
                state_next       = S_DONE;
            end
            S_Q_RD:
            begin
                state_next = S_Q_CHK;
            end
            S_Q_CHK:
            begin
                pend_answer_next = (pair_cost > total_reg) ? '0 : (total_reg - pair_cost);
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_merged_next = pend_merged_reg;
                    res_weight_next = total_reg;
                    res_answer_next = pend_answer_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        cost_reg        <= cost_next;
        cur_reg         <= cur_next;
        ru_reg          <= ru_next;
        rv_reg          <= rv_next;
        pa_reg          <= pa_next;
        pb_reg          <= pb_next;
        rank_u_reg      <= rank_u_next;
        tail_u_reg      <= tail_u_next;
        pend_merged_reg <= pend_merged_next;
        pend_answer_reg <= pend_answer_next;
        res_merged_reg  <= res_merged_next;
        res_weight_reg  <= res_weight_next;
        res_answer_reg  <= res_answer_next;
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_wa] <= par_wd;
        end
        par_rd_reg <= par_mem[par_ra];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_wa] <= rank_wd;
        end
        rank_rd_reg <= rank_mem[rank_ra];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd_reg <= next_mem[next_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tail_we)
        begin
            tail_mem[tail_wa] <= tail_wd;
        end
        tail_rd_reg <= tail_mem[tail_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pair_we)
        begin
            pair_mem[pair_wa] <= pair_wd;
        end
        pair_rd_reg <= pair_mem[pair_ra];
    end

endmodule
`default_nettype wire

### hdl/kruskal_bottleneck_pair_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kruskal_bottleneck_pair_table
// Minimum spanning forest builder with a per-pair bottleneck cost table.
// ----------------------------------------------------------------------------
// Edges must arrive in nondecreasing cost order; each beat gives exactly one
// result beat. After reset the block initializes its forest memories and
// takes no beat until that is done. Node pairs that are joined are recognized
// by a common root, so the pair table needs no clearing. Work is done one
// item at a time by a sequencer over memories with one read and one write
// port: a root search reads the parent of each node on the path up to and
// including the root, an added edge that merges components writes the pair
// table for every cross pair (two pair table writes per cross pair) and then
// updates parents, ranks and member lists, and a query of joined nodes reads
// the pair table. A two-beat queue in front lets items be taken while one is at work.
// ----------------------------------------------------------------------------
module kruskal_bottleneck_pair_table #(
    parameter int NODE_COUNT = 64,
    parameter int COST_WIDTH = 30
) (
    input  logic          clk,
    input  logic          rst_n,
    kbpt_item_if.sink     item,
    kbpt_result_if.source result
);

    logic           push;
    kbpt_pkg::cmd_t push_cmd;
    logic           queue_full;
    logic           pop;
    logic           pop_valid;
    kbpt_pkg::cmd_t pop_cmd;
    logic           init_done;

    kbpt_front #(
        .NODE_COUNT(NODE_COUNT)
    ) u_front (
        .item      (item),
        .queue_full(queue_full),
        .init_done (init_done),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    kbpt_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .pop_valid(pop_valid),
        .pop_cmd  (pop_cmd)
    );

    kbpt_back #(
        .NODE_COUNT(NODE_COUNT),
        .COST_WIDTH(COST_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (pop_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (pop),
        .init_done(init_done),
        .result   (result)
    );

endmodule
`default_nettype wire

### hdl/kbpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kbpt_checker
// Port level checks on result beats of the spanning forest block.
// ----------------------------------------------------------------------------
module kbpt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         res_merged,
    input logic [kbpt_pkg::TOTAL_W-1:0] res_weight,
    input logic [kbpt_pkg::TOTAL_W-1:0] res_answer
);

    logic                         seen_reg;
    logic                         seen_next;
    logic [kbpt_pkg::TOTAL_W-1:0] last_weight_reg;
    logic [kbpt_pkg::TOTAL_W-1:0] last_weight_next;

    always_comb
    begin
        seen_next        = seen_reg || (res_valid && res_ready);
        last_weight_next = (res_valid && res_ready) ? res_weight : last_weight_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg        <= 1'b0;
            last_weight_reg <= '0;
        end
        else
        begin
            seen_reg        <= seen_next;
            last_weight_reg <= last_weight_next;
        end
    end

    // A stalled result beat keeps its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_merged)
            && $stable(res_weight) && $stable(res_answer))
        else $error("result beat changed while stalled");

    // A merging edge beat carries no query answer.
    a_merge_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_merged |-> res_answer == '0)
        else $error("merged beat with nonzero answer");

    // The answer never exceeds the tree weight it was taken from.
    a_answer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_answer <= res_weight)
        else $error("answer above tree weight");

    // The tree weight never decreases from one delivered beat to the next.
    a_weight_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && seen_reg |-> res_weight >= last_weight_reg)
        else $error("tree weight decreased");

endmodule

bind kruskal_bottleneck_pair_table kbpt_checker u_kbpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_merged(result.merged),
    .res_weight(result.tree_weight),
    .res_answer(result.query_answer)
);
`default_nettype wire

### verif/kbpt_tb_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbpt testbench channel note
// The block's own channel interfaces are used directly; this file holds the
// small record types that the bench keeps in its queues.
// ----------------------------------------------------------------------------
package kbpt_tb_pkg;

    typedef struct packed {
        logic        operation;
        logic [5:0]  node_a;
        logic [5:0]  node_b;
        logic [29:0] edge_cost;
    } edge_query_t;

    typedef struct packed {
        logic        merged;
        logic [35:0] tree_weight;
        logic [35:0] query_answer;
    } forest_result_t;

endpackage

### verif/tb_kruskal_bottleneck_pair_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kruskal_bottleneck_pair_table
// Drives edge and query beats into the spanning forest block and checks every
// result beat against a union-find predictor kept inside the bench, under
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_kruskal_bottleneck_pair_table;

    localparam int NODES = 64;
    localparam logic [35:0] WEIGHT_MAX = 36'hF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    kbpt_item_if   item ();
    kbpt_result_if result ();

    kruskal_bottleneck_pair_table u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    always #4 clk = ~clk;

    logic [5:0]  link [NODES];
    logic [2:0]  rank_of [NODES];
    logic [5:0]  next_member [NODES];
    logic [5:0]  tail_member [NODES];
    logic [29:0] pair_cost [NODES*NODES];
    logic [35:0] weight_sum;

    kbpt_tb_pkg::edge_query_t    pending_items [$];
    kbpt_tb_pkg::forest_result_t awaited_results [$];

    int  send_idle_pct = 38;
    int  recv_idle_pct = 64;
    bit  hold_recv = 1'b0;
    bit  hold_start = 1'b0;
    int  hold_left = 0;
    bit  beat_taken = 1'b0;
    bit  pause_send = 1'b0;
    int  failures = 0;
    longint cycles = 0;
    logic [29:0] cost_floor = '0;

    function automatic logic [5:0] root_walk(input logic [5:0] n);
        logic [5:0] r;
        logic [5:0] up;
        r = n;
        while (link[r] != r) r = link[r];
        while (n != r)
        begin
            up = link[n];
            link[n] = r;
            n = up;
        end
        return r;
    endfunction

    function automatic kbpt_tb_pkg::forest_result_t apply_item(
        input kbpt_tb_pkg::edge_query_t it);
        kbpt_tb_pkg::forest_result_t res;
        logic [5:0] ru, rv, t, a, b;
        logic [36:0] sum;
        res = '0;
        if (it.operation == kbpt_pkg::OP_EDGE)
        begin
            ru = root_walk(it.node_a);
            rv = root_walk(it.node_b);
            if (ru != rv)
            begin
                a = ru;
                forever
                begin
                    b = rv;
                    forever
                    begin
                        pair_cost[a*NODES+b] = it.edge_cost;
                        pair_cost[b*NODES+a] = it.edge_cost;
                        if (next_member[b] == b) break;
                        b = next_member[b];
                    end
                    if (next_member[a] == a) break;
                    a = next_member[a];
                end
                if (rank_of[ru] > rank_of[rv])
                begin
                    t = ru;
                    ru = rv;
                    rv = t;
                end
                link[ru] = rv;
                next_member[tail_member[rv]] = ru;
                tail_member[rv] = tail_member[ru];
                if (rank_of[ru] == rank_of[rv] && rank_of[rv] < kbpt_pkg::RANK_MAX)
                    rank_of[rv] = rank_of[rv] + 3'd1;
                sum = weight_sum + it.edge_cost;
                weight_sum = (sum > WEIGHT_MAX) ? WEIGHT_MAX : sum[35:0];
                res.merged = 1'b1;
            end
        end
        else
        begin
            if (pair_cost[it.node_a*NODES+it.node_b] > weight_sum)
                res.query_answer = '0;
            else
                res.query_answer = weight_sum - pair_cost[it.node_a*NODES+it.node_b];
        end
        res.tree_weight = weight_sum;
        return res;
    endfunction

    task automatic add_item(input logic op, input int na, input int nb,
                            input logic [29:0] cost);
        kbpt_tb_pkg::edge_query_t it;
        it.operation = op;
        it.node_a = na[5:0];
        it.node_b = nb[5:0];
        it.edge_cost = cost;
        pending_items = {pending_items, it};
    endtask

    task automatic add_edge(input int na, input int nb, input int step);
        logic [29:0] c;
        c = cost_floor + step[29:0];
        if (c < cost_floor) c = 30'h3FFF_FFFF;
        cost_floor = c;
        add_item(kbpt_pkg::OP_EDGE, na, nb, c);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_node(input int span);
        return (span >= 64) ? $urandom_range(0, 63) : $urandom_range(0, span - 1);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item.valid || beat_taken)
            begin
                if (pending_items.size() != 0 && !pause_send
                    && ($urandom_range(0, 99) >= send_idle_pct))
                begin
                    item.valid     <= 1'b1;
                    item.operation <= pending_items[0].operation;
                    item.node_a    <= pending_items[0].node_a;
                    item.node_b    <= pending_items[0].node_b;
                    item.edge_cost <= pending_items[0].edge_cost;
                end
                else
                    item.valid <= 1'b0;
            end
            result.ready <= !hold_recv && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (hold_recv)
        begin
            if (hold_left <= 1)
                hold_recv <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_start)
        begin
            hold_recv <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge clk)
    begin
        kbpt_tb_pkg::forest_result_t want;
        kbpt_tb_pkg::edge_query_t    took;
        beat_taken = rst_n && item.valid && item.ready;
        cycles <= cycles + 1;
        if (beat_taken)
        begin
            took = pending_items.pop_front();
            awaited_results = {awaited_results, apply_item(took)};
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                failures++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.merged !== want.merged)
                begin
                    $error("merged: expected %0d, got %0d", want.merged, result.merged);
                    failures++;
                end
                if (result.tree_weight !== want.tree_weight)
                begin
                    $error("tree_weight: expected %0d, got %0d",
                           want.tree_weight, result.tree_weight);
                    failures++;
                end
                if (result.query_answer !== want.query_answer)
                begin
                    $error("query_answer: expected %0d, got %0d",
                           want.query_answer, result.query_answer);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        int span;
        int k;
        item.valid = 1'b0;
        item.operation = kbpt_pkg::OP_EDGE;
        item.node_a = '0;
        item.node_b = '0;
        item.edge_cost = '0;
        result.ready = 1'b0;
        for (int i = 0; i < NODES; i++)
        begin
            link[i] = 6'(i);
            rank_of[i] = '0;
            next_member[i] = 6'(i);
            tail_member[i] = 6'(i);
        end
        for (int i = 0; i < NODES*NODES; i++) pair_cost[i] = '0;
        weight_sum = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: extremes, self loops, same node and unjoined queries.
        add_item(kbpt_pkg::OP_QUERY, 0, 63, 30'h3FFF_FFFF);
        add_item(kbpt_pkg::OP_QUERY, 5, 5, 30'd0);
        add_item(kbpt_pkg::OP_EDGE, 7, 7, 30'd3);
        add_item(kbpt_pkg::OP_EDGE, 0, 63, 30'd0);
        add_item(kbpt_pkg::OP_QUERY, 0, 63, 30'd0);
        add_item(kbpt_pkg::OP_EDGE, 1, 2, 30'h1555_5555);
        add_item(kbpt_pkg::OP_EDGE, 2, 1, 30'h1555_5555);
        add_item(kbpt_pkg::OP_EDGE, 62, 1, 30'h2AAA_AAAA);
        add_item(kbpt_pkg::OP_EDGE, 63, 2, 30'h3FFF_FFFF);
        add_item(kbpt_pkg::OP_QUERY, 63, 62, 30'd0);
        add_item(kbpt_pkg::OP_QUERY, 0, 2, 30'd0);
        add_item(kbpt_pkg::OP_QUERY, 3, 4, 30'd0);
        add_item(kbpt_pkg::OP_QUERY, 42, 21, 30'h2AAA_AAAA);
        add_item(kbpt_pkg::OP_EDGE, 42, 21, 30'd1);
        add_item(kbpt_pkg::OP_QUERY, 21, 42, 30'd0);
        add_item(kbpt_pkg::OP_QUERY, 1, 62, 30'd0);
        cost_floor = 30'h3FFF_FFFF;

        // Random part: the forest grows on with sorted costs, with some out of order.
        n = 0;
        k = 0;
        while (n < 1350)
        begin
            if (n == 450)
            begin
                wait_drained();
                send_idle_pct = 64;
                recv_idle_pct = 38;
                hold_start = 1'b1;
                wait (hold_recv);
                hold_start = 1'b0;
                for (int j = 0; j < 30; j++)
                    add_item(kbpt_pkg::OP_QUERY, j, 63 - j, 30'd0);
                n += 30;
                wait (!hold_recv);
            end
            if (n >= 900 && k == 0)
            begin
                wait_drained();
                pause_send = 1'b1;
                repeat (40) @(posedge clk);
                pause_send = 1'b0;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                k = 1;
            end
            span = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(2, 16);
            if ($urandom_range(0, 9) < 6)
            begin
                if ($urandom_range(0, 19) == 0)
                    add_item(kbpt_pkg::OP_EDGE, pick_node(span), pick_node(span),
                             30'($urandom()));
                else
                    add_edge(pick_node(span), pick_node(span),
                             ($urandom_range(0, 3) == 0) ? $urandom()
                                                         : $urandom_range(0, 1000));
            end
            else
                add_item(kbpt_pkg::OP_QUERY, pick_node(span), pick_node(span),
                         30'($urandom()));
            n++;
            if (pending_items.size() > 40)
                while (pending_items.size() > 4) @(posedge clk);
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### files.f
hdl/kbpt_pkg.sv
hdl/kbpt_channels.sv
hdl/kbpt_front.sv
hdl/kbpt_cmd_queue.sv
hdl/kbpt_back.sv
hdl/kruskal_bottleneck_pair_table.sv
hdl/kbpt_checker.sv
verif/kbpt_tb_channels.sv
verif/tb_kruskal_bottleneck_pair_table.sv
